FILE: src/sorted_array_min_priority_queue_top_defines.svh
// Assertion macros for the sorted array min priority queue checker.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef SORTED_ARRAY_MIN_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_ARRAY_MIN_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SAPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SAPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/sapq_pkg.sv
// Package for the sorted array min priority queue.
// Holds payload structs, codes, controller states and control/status structs.
`default_nettype none

package sapq_pkg;

  localparam int DATA_W    = 32;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int CNT_OUT_W = 5;
  localparam int CAP_W     = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Operation codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] item_value;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] head_value;
    logic [CNT_OUT_W-1:0]     count_after;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CHK,
    S_INS_CMP,
    S_PEEK,
    S_POP,
    S_SH_CHK,
    S_SH_WR
  } state_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_LOAD,
    IDX_ZERO,
    IDX_DEC,
    IDX_INC
  } idx_op_e;

  typedef enum logic [1:0] {
    RD_HEAD,
    RD_BELOW,
    RD_ABOVE
  } rd_sel_e;

  typedef enum logic {
    WR_VAL,
    WR_RDATA
  } wr_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  typedef enum logic [1:0] {
    HEAD_ZERO,
    HEAD_RDATA,
    HEAD_HELD
  } head_sel_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic                ld_val;
    idx_op_e             idx_op;
    logic                rd_en;
    rd_sel_e             rd_sel;
    logic                wr_en;
    wr_sel_e             wr_sel;
    cnt_op_e             cnt_op;
    logic                head_ld;
    logic                emit;
    logic [STATUS_W-1:0] emit_status;
    head_sel_e           head_sel;
  } ctl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic idx_zero;
    logic greater;
    logic shift_done;
  } sts_t;

endpackage

`default_nettype wire

FILE: src/sorted_array_min_priority_queue_top.sv
// Top level of the sorted array min priority queue.
// Instantiates sapq_ctrl and sapq_datapath; uses sapq_pkg.
//
// Minimum-first queue of signed 32-bit values kept ascending in a
// DEPTH-entry memory with one write and one registered read port. An item
// is taken when start is high and busy is low; its one result appears on
// res_o for exactly one cycle with res_strobe_o high, the cycle after the
// item completes, and cannot be stalled. Inserts and removes walk the
// memory with one read and one write per moved entry; a refused insert,
// an empty answer or an unused command is answered from idle, and a peek
// only reads the head entry. A new item may be started on the cycle its
// predecessor's result is shown. The capacity register may be written at
// any cycle while no item is in progress.
`default_nettype none

module sorted_array_min_priority_queue_top #(
  parameter int DEPTH = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start,
  output logic                         busy,
  input  wire sapq_pkg::in_t           req_i,
  output logic                         res_strobe_o,
  output sapq_pkg::out_t               res_o,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [sapq_pkg::CAP_W-1:0]    cfg_data_i
);
  import sapq_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  sapq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (req_i.cmd),
    .sts_i  (sts),
    .ctl_o  (ctl),
    .busy   (busy)
  );

  sapq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .val_i        (req_i.item_value),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

endmodule

`default_nettype wire

FILE: src/sapq_datapath.sv
// Datapath of the sorted array min priority queue: entry memory, count,
// capacity register, walk index and result register. Uses sapq_pkg.
`default_nettype none

module sapq_datapath #(
  parameter int DEPTH = 16
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire sapq_pkg::ctl_t            ctl_i,
  output sapq_pkg::sts_t                 sts_o,
  input  wire [sapq_pkg::DATA_W-1:0]     val_i,
  input  wire                            cfg_we_i,
  input  wire [sapq_pkg::CAP_W-1:0]      cfg_data_i,
  output logic                           res_strobe_o,
  output sapq_pkg::out_t                 res_o
);
  import sapq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int XW = (CW > CAP_W) ? CW : CAP_W;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata_q;
  logic signed [DATA_W-1:0] val_q;
  logic signed [DATA_W-1:0] head_q;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [CW-1:0]            idx_q, idx_d;
  logic [CAP_W-1:0]         cap_q;
  logic [AW-1:0]            raddr;
  logic [AW-1:0]            waddr;
  logic signed [DATA_W-1:0] wdata;
  logic [XW-1:0]            cap_x, eff_cap;
  logic [CW:0]              idx_up;
  logic [CW-1:0]            idx_dn;
  logic signed [DATA_W-1:0] head_mux;
  out_t                     res_q;
  logic                     strobe_q;

  // Effective capacity: zero acts as one, above DEPTH acts as DEPTH
  always_comb begin
    cap_x = XW'(cap_q);
    if (cap_x == '0) begin
      eff_cap = XW'(1);
    end else if (cap_x > XW'(DEPTH)) begin
      eff_cap = XW'(DEPTH);
    end else begin
      eff_cap = cap_x;
    end
  end

  assign idx_up = {1'b0, idx_q} + (CW+1)'(1);
  assign idx_dn = idx_q - CW'(1);

  // Status toward the controller
  always_comb begin
    sts_o.full       = XW'(cnt_q) >= eff_cap;
    sts_o.empty      = (cnt_q == '0);
    sts_o.idx_zero   = (idx_q == '0);
    sts_o.greater    = rdata_q > val_q;
    sts_o.shift_done = idx_up >= {1'b0, cnt_q};
  end

  // Select read address
  always_comb begin
    case (ctl_i.rd_sel)
      RD_BELOW: raddr = idx_dn[AW-1:0];
      RD_ABOVE: raddr = idx_up[AW-1:0];
      default:  raddr = '0;
    endcase
  end

  assign waddr = idx_q[AW-1:0];
  assign wdata = (ctl_i.wr_sel == WR_RDATA) ? rdata_q : val_q;

  // Entry memory, registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  // Next index and count
  always_comb begin
    case (ctl_i.idx_op)
      IDX_LOAD: idx_d = cnt_q;
      IDX_ZERO: idx_d = '0;
      IDX_DEC:  idx_d = idx_dn;
      IDX_INC:  idx_d = idx_up[CW-1:0];
      default:  idx_d = idx_q;
    endcase
    case (ctl_i.cnt_op)
      CNT_INC: cnt_d = cnt_q + CW'(1);
      CNT_DEC: cnt_d = cnt_q - CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  // Hold operand, head and index
  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_val) begin
      val_q <= val_i;
    end
    if (ctl_i.head_ld) begin
      head_q <= rdata_q;
    end
    idx_q <= idx_d;
  end

  // Control state: count and capacity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      cap_q <= CAP_RESET;
    end else begin
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    case (ctl_i.head_sel)
      HEAD_RDATA: head_mux = rdata_q;
      HEAD_HELD:  head_mux = head_q;
      default:    head_mux = '0;
    endcase
  end

  // Result register and strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= ctl_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      res_q.status      <= ctl_i.emit_status;
      res_q.head_value  <= head_mux;
      res_q.count_after <= CNT_OUT_W'(cnt_d);
    end
  end

  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule

`default_nettype wire

FILE: src/sapq_ctrl.sv
// Controller of the sorted array min priority queue: state machine that
// sequences memory walks for insert and remove. Uses sapq_pkg.
`default_nettype none

module sapq_ctrl (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start,
  input  wire [sapq_pkg::CMD_W-1:0]   cmd_i,
  input  wire sapq_pkg::sts_t         sts_i,
  output sapq_pkg::ctl_t              ctl_o,
  output logic                        busy
);
  import sapq_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (cmd_i)
            CMD_INSERT: state_d = sts_i.full  ? S_IDLE : S_INS_CHK;
            CMD_REMOVE: state_d = sts_i.empty ? S_IDLE : S_POP;
            CMD_PEEK:   state_d = sts_i.empty ? S_IDLE : S_PEEK;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_INS_CHK: state_d = sts_i.idx_zero ? S_IDLE : S_INS_CMP;
      S_INS_CMP: state_d = sts_i.greater ? S_INS_CHK : S_IDLE;
      S_PEEK:    state_d = S_IDLE;
      S_POP:     state_d = S_SH_CHK;
      S_SH_CHK:  state_d = sts_i.shift_done ? S_IDLE : S_SH_WR;
      S_SH_WR:   state_d = S_SH_CHK;
      default:   state_d = S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    ctl_o             = '0;
    ctl_o.idx_op      = IDX_HOLD;
    ctl_o.rd_sel      = RD_HEAD;
    ctl_o.wr_sel      = WR_VAL;
    ctl_o.cnt_op      = CNT_HOLD;
    ctl_o.emit_status = STAT_OK;
    ctl_o.head_sel    = HEAD_ZERO;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          ctl_o.ld_val = 1'b1;
          ctl_o.idx_op = IDX_LOAD;
          case (cmd_i)
            CMD_INSERT: begin
              if (sts_i.full) begin
                ctl_o.emit        = 1'b1;
                ctl_o.emit_status = STAT_FULL;
              end
            end
            CMD_REMOVE, CMD_PEEK: begin
              if (sts_i.empty) begin
                ctl_o.emit        = 1'b1;
                ctl_o.emit_status = STAT_EMPTY;
              end else begin
                ctl_o.rd_en  = 1'b1;
                ctl_o.rd_sel = RD_HEAD;
              end
            end
            default: begin
              // unused command answers ok with no change
              ctl_o.emit = 1'b1;
            end
          endcase
        end
      end
      S_INS_CHK: begin
        if (sts_i.idx_zero) begin
          ctl_o.wr_en  = 1'b1;
          ctl_o.wr_sel = WR_VAL;
          ctl_o.cnt_op = CNT_INC;
          ctl_o.emit   = 1'b1;
        end else begin
          ctl_o.rd_en  = 1'b1;
          ctl_o.rd_sel = RD_BELOW;
        end
      end
      S_INS_CMP: begin
        ctl_o.wr_en = 1'b1;
        if (sts_i.greater) begin
          // move the larger entry up one slot
          ctl_o.wr_sel = WR_RDATA;
          ctl_o.idx_op = IDX_DEC;
        end else begin
          ctl_o.wr_sel = WR_VAL;
          ctl_o.cnt_op = CNT_INC;
          ctl_o.emit   = 1'b1;
        end
      end
      S_PEEK: begin
        ctl_o.emit     = 1'b1;
        ctl_o.head_sel = HEAD_RDATA;
      end
      S_POP: begin
        ctl_o.head_ld = 1'b1;
        ctl_o.idx_op  = IDX_ZERO;
      end
      S_SH_CHK: begin
        if (sts_i.shift_done) begin
          ctl_o.cnt_op   = CNT_DEC;
          ctl_o.emit     = 1'b1;
          ctl_o.head_sel = HEAD_HELD;
        end else begin
          ctl_o.rd_en  = 1'b1;
          ctl_o.rd_sel = RD_ABOVE;
        end
      end
      S_SH_WR: begin
        // move the next entry down one slot
        ctl_o.wr_en  = 1'b1;
        ctl_o.wr_sel = WR_RDATA;
        ctl_o.idx_op = IDX_INC;
      end
      default: begin
        ctl_o.emit = 1'b0;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

FILE: src/sapq_checker.sv
// Port-level checker for the sorted array min priority queue, bound to
// the top level. Uses sapq_pkg and the assertion macros header.
`default_nettype none

`include "sorted_array_min_priority_queue_top_defines.svh"

module sapq_checker (
  input wire                         clk_i,
  input wire                         rst_ni,
  input wire                         start,
  input wire                         busy,
  input wire                         res_strobe_o,
  input wire sapq_pkg::out_t         res_o
);
  import sapq_pkg::*;

  // An accepted item either keeps the block busy or answers at once
  `SAPQ_ASSERT_NEXT(a_accept_progress, start && !busy, busy || res_strobe_o, "item lost")

  // A result is shown only once the block is free again
  `SAPQ_ASSERT_NOW(a_strobe_idle, res_strobe_o, !busy, "result while busy")

  // A result follows an accept or a busy cycle
  `SAPQ_ASSERT_NOW(a_strobe_cause, res_strobe_o, $past(busy) || $past(start), "stray result")

  // Refused or empty answers carry a zero head value
  `SAPQ_ASSERT_NOW(a_fail_zero_head, res_strobe_o && (res_o.status != STAT_OK), res_o.head_value == 0, "head not zero")

  // An empty answer reports an empty queue
  `SAPQ_ASSERT_NOW(a_empty_count, res_strobe_o && (res_o.status == STAT_EMPTY), res_o.count_after == 0, "empty with entries")

endmodule

bind sorted_array_min_priority_queue_top sapq_checker u_sapq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .res_strobe_o (res_strobe_o),
  .res_o        (res_o)
);

`default_nettype wire
